// ===== rtl/scc_pkg.sv =====
// Shared types, constants and helper functions for the segment cylinder clipper.
// Used by every module of the block; depends on nothing.
package scc_pkg;

  // Bisection steps per clip and depth of the front/back queue
  localparam int STEPS     = 34;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  // Short segment threshold: 0.0001 cm^2 in Q32.32
  localparam logic [21:0] LEN_SQ_MIN = 22'd429497;
  localparam logic [32:0] LONG_LIM   = 33'd1024;

  // Configuration register indexes
  localparam logic [2:0] REG_RADIUS     = 3'd0;
  localparam logic [2:0] REG_Z_LOW      = 3'd1;
  localparam logic [2:0] REG_Z_HIGH     = 3'd2;
  localparam logic [2:0] REG_ENERGY_MIN = 3'd3;
  localparam logic [2:0] REG_EN_PHOTON  = 3'd4;
  localparam logic [2:0] REG_EN_ELEC    = 3'd5;
  localparam logic [2:0] REG_EN_POSI    = 3'd6;

  // Particle codes
  localparam logic [1:0] PT_PHOTON   = 2'd0;
  localparam logic [1:0] PT_ELECTRON = 2'd1;
  localparam logic [1:0] PT_POSITRON = 2'd2;
  localparam logic [1:0] PT_OTHER    = 2'd3;

  typedef enum logic [2:0] {
    KIND_RAD = 3'b001,
    KIND_ZLO = 3'b010,
    KIND_ZHI = 3'b100
  } kind_t;

  typedef logic signed [31:0] coord_t;
  typedef coord_t [2:0] point_t;

  // One segment in flight: anc is the fixed end, a/b bracket the clipped end
  typedef struct packed {
    logic       valid;
    logic       drop;
    logic [1:0] particle;
    logic       clip_en;
    logic       swap;
    point_t     anc;
    point_t     a;
    point_t     b;
  } seg_t;

  typedef struct packed {
    logic [63:0] r2;
    coord_t      z_low;
    coord_t      z_high;
  } geom_t;

  typedef struct packed {
    logic [2:0]  en;
    logic [31:0] energy_min;
  } filt_t;

  function automatic coord_t floor_mid(input coord_t x, input coord_t y);
    logic signed [32:0] s;
    s = {x[31], x} + {y[31], y};
    return s[32:1];
  endfunction

  function automatic logic [31:0] mag(input coord_t x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic point_t seg_p0(input seg_t s);
    return s.swap ? s.a : s.anc;
  endfunction

  function automatic point_t seg_p1(input seg_t s);
    return s.swap ? s.anc : s.a;
  endfunction

  // Build the clip setup for a z plane from the current endpoints
  function automatic seg_t setup_z(input seg_t s, input kind_t kind, input geom_t g);
    seg_t   r;
    point_t p0;
    point_t p1;
    logic   c0;
    logic   c1;
    p0 = seg_p0(s);
    p1 = seg_p1(s);
    if (kind == KIND_ZLO) begin
      c0 = $signed(p0[2]) < $signed(g.z_low);
      c1 = $signed(p1[2]) < $signed(g.z_low);
    end else begin
      c0 = $signed(p0[2]) > $signed(g.z_high);
      c1 = $signed(p1[2]) > $signed(g.z_high);
    end
    r         = s;
    r.swap    = c0;
    r.clip_en = c0 | c1;
    r.anc     = c0 ? p1 : p0;
    r.a       = (c0 | c1) ? (c0 ? p1 : p0) : p1;
    r.b       = c0 ? p0 : p1;
    return r;
  endfunction

endpackage

// ===== rtl/scc_if.sv =====
// Valid/ready channel interfaces for segment items and clipped result items.
// Depends on nothing.
interface scc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  particle;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic [31:0] energy;
  modport source (output valid, particle, start_x, start_y, start_z, end_x, end_y, end_z,
                  energy, input ready);
  modport sink (input valid, particle, start_x, start_y, start_z, end_x, end_y, end_z,
                energy, output ready);
endinterface

interface scc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_particle;
  logic signed [31:0] clip_start_x;
  logic signed [31:0] clip_start_y;
  logic signed [31:0] clip_start_z;
  logic signed [31:0] clip_end_x;
  logic signed [31:0] clip_end_y;
  logic signed [31:0] clip_end_z;
  modport source (output valid, out_particle, clip_start_x, clip_start_y, clip_start_z,
                  clip_end_x, clip_end_y, clip_end_z, input ready);
  modport sink (input valid, out_particle, clip_start_x, clip_start_y, clip_start_z,
                clip_end_x, clip_end_y, clip_end_z, output ready);
endinterface

// ===== rtl/scc_front.sv =====
// Front end: accepts segment items, filters by type and energy, runs the radial
// end tests and sets up the radial clip. Depends on scc_pkg and scc_in_if.
module scc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  scc_pkg::filt_t filt,
  input  scc_pkg::geom_t geom,
  scc_in_if.sink        in_ch,
  output logic          push,
  output scc_pkg::seg_t push_data
);
  import scc_pkg::*;

  logic        f1_valid_r, f2_valid_r;
  logic        f1_drop_r, f2_drop_r;
  logic [1:0]  f1_pt_r, f2_pt_r;
  point_t      f1_p0_r, f1_p1_r, f2_p0_r, f2_p1_r;
  logic [63:0] sq0x_r, sq0y_r, sq1x_r, sq1y_r;
  logic        type_ok;
  logic [63:0] r0, r1;
  logic        out_all, swap, clip_en;
  point_t      anc;

  assign in_ch.ready = adv;

  // Type enable decode
  always_comb begin
    unique case (in_ch.particle)
      PT_PHOTON:   type_ok = filt.en[0];
      PT_ELECTRON: type_ok = filt.en[1];
      PT_POSITRON: type_ok = filt.en[2];
      default:     type_ok = 1'b0;
    endcase
  end

  // Stage 1: capture item and filter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (adv) begin
      f1_valid_r <= in_ch.valid;
      f1_drop_r  <= !type_ok || (in_ch.energy < filt.energy_min);
      f1_pt_r    <= in_ch.particle;
      f1_p0_r    <= {in_ch.start_z, in_ch.start_y, in_ch.start_x};
      f1_p1_r    <= {in_ch.end_z, in_ch.end_y, in_ch.end_x};
    end
  end

  // Stage 2: squares of the xy coordinates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_valid_r <= 1'b0;
    end else if (adv) begin
      f2_valid_r <= f1_valid_r;
      f2_drop_r  <= f1_drop_r;
      f2_pt_r    <= f1_pt_r;
      f2_p0_r    <= f1_p0_r;
      f2_p1_r    <= f1_p1_r;
      sq0x_r     <= mag(f1_p0_r[0]) * mag(f1_p0_r[0]);
      sq0y_r     <= mag(f1_p0_r[1]) * mag(f1_p0_r[1]);
      sq1x_r     <= mag(f1_p1_r[0]) * mag(f1_p1_r[0]);
      sq1y_r     <= mag(f1_p1_r[1]) * mag(f1_p1_r[1]);
    end
  end

  // Radial classification and clip setup
  always_comb begin
    r0      = sq0x_r + sq0y_r;
    r1      = sq1x_r + sq1y_r;
    out_all = (r0 >= geom.r2) && (r1 >= geom.r2);
    swap    = r0 > geom.r2;
    clip_en = swap || (r1 > geom.r2);
    anc     = swap ? f2_p1_r : f2_p0_r;
    push    = adv && f2_valid_r && !f2_drop_r && !out_all;
    push_data          = '0;
    push_data.valid    = 1'b1;
    push_data.particle = f2_pt_r;
    push_data.swap     = swap;
    push_data.clip_en  = clip_en;
    push_data.anc      = anc;
    push_data.a        = clip_en ? anc : f2_p1_r;
    push_data.b        = swap ? f2_p0_r : f2_p1_r;
  end

endmodule

// ===== rtl/scc_fifo.sv =====
// Short queue of segment items between the front and back ends.
// Depends on scc_pkg.
module scc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  scc_pkg::seg_t wdata,
  input  logic          pop,
  output scc_pkg::seg_t rdata,
  output logic          full,
  output logic          empty
);
  import scc_pkg::*;

  seg_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full  = count_r == (QPTR_W+1)'(QDEPTH);
  assign empty = count_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/scc_bisect_step.sv =====
// One bisection step in three stages: midpoint, squares, inside test and select.
// Depends on scc_pkg.
module scc_bisect_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  scc_pkg::kind_t kind,
  input  scc_pkg::geom_t geom,
  input  scc_pkg::seg_t  d,
  output scc_pkg::seg_t  q
);
  import scc_pkg::*;

  seg_t        s1_r, s2_r, s3_r, s3_nxt;
  point_t      mid, m1_r, m2_r;
  logic [63:0] sqx_r, sqy_r;
  logic        in_pt;

  always_comb begin
    for (int i = 0; i < 3; i++) mid[i] = floor_mid(d.a[i], d.b[i]);
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r  <= d;
      m1_r  <= mid;
      s2_r  <= s1_r;
      m2_r  <= m1_r;
      sqx_r <= mag(m1_r[0]) * mag(m1_r[0]);
      sqy_r <= mag(m1_r[1]) * mag(m1_r[1]);
      s3_r  <= s3_nxt;
    end
  end

  // Inside test for the midpoint
  always_comb begin
    unique case (kind)
      KIND_RAD: in_pt = (sqx_r + sqy_r) <= geom.r2;
      KIND_ZLO: in_pt = $signed(m2_r[2]) >= $signed(geom.z_low);
      KIND_ZHI: in_pt = $signed(m2_r[2]) <= $signed(geom.z_high);
      default:  in_pt = 1'b0;
    endcase
    s3_nxt = s2_r;
    if (s2_r.clip_en) begin
      if (in_pt) s3_nxt.a = m2_r;
      else       s3_nxt.b = m2_r;
    end
  end

  assign q = s3_r;

endmodule

// ===== rtl/scc_back.sv =====
// Back end: radial bisection chain, z drop and length test, then z_low and
// z_high bisection chains. Depends on scc_pkg and scc_bisect_step.
module scc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  scc_pkg::geom_t geom,
  input  scc_pkg::seg_t head,
  output scc_pkg::seg_t tail
);
  import scc_pkg::*;

  seg_t rad [STEPS+1];
  seg_t zlo [STEPS+1];
  seg_t zhi [STEPS+1];
  seg_t ck_r, ck_nxt, zs_r;
  point_t p0, p1;
  logic   zdrop, is_long;
  logic [32:0] dm;
  logic [21:0] len;

  assign rad[0] = head;

  for (genvar k = 0; k < STEPS; k++) begin : g_rad
    scc_bisect_step u_step (.clk, .rst_n, .adv, .kind(KIND_RAD), .geom,
                            .d(rad[k]), .q(rad[k+1]));
  end

  // Z drop and short segment tests, then z_low setup
  always_comb begin
    p0      = seg_p0(rad[STEPS]);
    p1      = seg_p1(rad[STEPS]);
    zdrop   = ($signed(p0[2]) <= $signed(geom.z_low) && $signed(p1[2]) <= $signed(geom.z_low))
           || ($signed(p0[2]) >= $signed(geom.z_high) && $signed(p1[2]) >= $signed(geom.z_high));
    is_long = 1'b0;
    len     = '0;
    for (int i = 0; i < 3; i++) begin
      dm = {p0[i][31], p0[i]} - {p1[i][31], p1[i]};
      dm = dm[32] ? (~dm + 33'd1) : dm;
      if (dm >= LONG_LIM) is_long = 1'b1;
      else len = len + 22'(dm[9:0] * dm[9:0]);
    end
    ck_nxt      = setup_z(rad[STEPS], KIND_ZLO, geom);
    ck_nxt.drop = rad[STEPS].drop || zdrop || (!is_long && len < LEN_SQ_MIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ck_r.valid <= 1'b0;
      zs_r.valid <= 1'b0;
    end else if (adv) begin
      ck_r <= ck_nxt;
      zs_r <= setup_z(zlo[STEPS], KIND_ZHI, geom);
    end
  end

  assign zlo[0] = ck_r;

  for (genvar k = 0; k < STEPS; k++) begin : g_zlo
    scc_bisect_step u_step (.clk, .rst_n, .adv, .kind(KIND_ZLO), .geom,
                            .d(zlo[k]), .q(zlo[k+1]));
  end

  assign zhi[0] = zs_r;

  for (genvar k = 0; k < STEPS; k++) begin : g_zhi
    scc_bisect_step u_step (.clk, .rst_n, .adv, .kind(KIND_ZHI), .geom,
                            .d(zhi[k]), .q(zhi[k+1]));
  end

  assign tail = zhi[STEPS];

endmodule

// ===== rtl/segment_cylinder_clipper.sv =====
// Segment cylinder clipper top level: config registers, front end, queue,
// back end and the output register. Depends on scc_pkg, scc_if and submodules.
// Throughput: one segment item per cycle while the queue is not full and the output
// is not stalled. Path from accept to result: 2 front stages, queue head, 3 x 34 bisection
// steps of 3 stages each, 2 setup stages, output register; a stalled output stalls the back chain.
// Reset: synchronous active low; clears config registers, pipeline valids and queue.
module segment_cylinder_clipper (
  input  logic        clk,
  input  logic        rst_n,
  scc_in_if.sink      in_ch,
  scc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import scc_pkg::*;

  logic [30:0] radius_r;
  logic [63:0] r2_r;
  coord_t      z_low_r, z_high_r;
  logic [31:0] energy_min_r;
  logic [2:0]  en_r;
  geom_t       geom;
  filt_t       filt;

  logic  fifo_push, fifo_pop, fifo_full, fifo_empty, back_adv;
  seg_t  push_data, fifo_rd, head, tail;
  point_t t0, t1;

  logic        out_valid_r;
  logic [1:0]  out_pt_r;
  point_t      out_p0_r, out_p1_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= '0;
      z_low_r      <= '0;
      z_high_r     <= '0;
      energy_min_r <= '0;
      en_r         <= '0;
      r2_r         <= '0;
    end else begin
      r2_r <= radius_r * radius_r;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RADIUS:     radius_r     <= cfg_wdata[30:0];
          REG_Z_LOW:      z_low_r      <= cfg_wdata;
          REG_Z_HIGH:     z_high_r     <= cfg_wdata;
          REG_ENERGY_MIN: energy_min_r <= cfg_wdata;
          REG_EN_PHOTON:  en_r[0]      <= cfg_wdata[0];
          REG_EN_ELEC:    en_r[1]      <= cfg_wdata[0];
          REG_EN_POSI:    en_r[2]      <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  assign geom = '{r2: r2_r, z_low: z_low_r, z_high: z_high_r};
  assign filt = '{en: en_r, energy_min: energy_min_r};

  scc_front u_front (
    .clk, .rst_n, .adv(!fifo_full), .filt, .geom, .in_ch,
    .push(fifo_push), .push_data
  );

  scc_fifo u_fifo (
    .clk, .rst_n, .push(fifo_push), .wdata(push_data), .pop(fifo_pop),
    .rdata(fifo_rd), .full(fifo_full), .empty(fifo_empty)
  );

  // Back chain advances whenever the output register can take an item
  assign back_adv = !out_valid_r || out_ch.ready;
  assign fifo_pop = back_adv && !fifo_empty;

  always_comb begin
    head       = fifo_rd;
    head.valid = !fifo_empty;
  end

  scc_back u_back (.clk, .rst_n, .adv(back_adv), .geom, .head, .tail);

  // Output register
  assign t0 = seg_p0(tail);
  assign t1 = seg_p1(tail);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (back_adv) begin
      out_valid_r <= tail.valid && !tail.drop;
      out_pt_r    <= tail.particle;
      out_p0_r    <= t0;
      out_p1_r    <= t1;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_particle = out_pt_r;
  assign out_ch.clip_start_x = out_p0_r[0];
  assign out_ch.clip_start_y = out_p0_r[1];
  assign out_ch.clip_start_z = out_p0_r[2];
  assign out_ch.clip_end_x   = out_p1_r[0];
  assign out_ch.clip_end_y   = out_p1_r[1];
  assign out_ch.clip_end_z   = out_p1_r[2];

  // Queue never written when full, never read when empty
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_empty) else $error("queue underflow");
  // Other particle types never reach the output
  a_no_other: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pt_r != PT_OTHER) else $error("other type emitted");

endmodule
